// ===== rtl/core/flv_tag_demuxer_defines.svh =====
// Assertion macros for the FLV tag demuxer.
// Used by the top level only; relies on clk and rst in the including scope.
`ifndef FLV_TAG_DEMUXER_DEFINES_SVH
`define FLV_TAG_DEMUXER_DEFINES_SVH

// cond must never hold outside reset
`define FLVTD_ASSERT_NEVER(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("flv_tag_demuxer: forbidden condition seen");

// ante implies cons in the same cycle
`define FLVTD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("flv_tag_demuxer: implication violated");

`endif

// ===== rtl/core/flvtd_pkg.sv =====
// Types and constants for the FLV tag demuxer.
// No dependencies.
package flvtd_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_FLAG    = 3'd1,
    PH_PKTTYPE = 3'd2,
    PH_CTS     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_SKIP    = 3'd5
  } phase_t;

  localparam logic [7:0] KIND_AUDIO   = 8'h08;
  localparam logic [7:0] KIND_VIDEO   = 8'h09;
  localparam logic [7:0] AUDIO_MASK   = 8'hF0;
  localparam logic [7:0] AUDIO_AAC    = 8'hA0;
  localparam logic [7:0] VIDEO_MASK   = 8'h0F;
  localparam logic [7:0] VIDEO_AVC    = 8'h07;
  localparam logic [7:0] PKT_RAW      = 8'h01;
  localparam logic [3:0] HDR_LAST_POS = 4'd14;
  localparam logic [2:0] CTS_BYTES    = 3'd3;

  typedef struct packed {
    phase_t      phase;
    logic [3:0]  hpos;
    logic [7:0]  kind;
    logic [23:0] left;
    logic [31:0] tag_time;
    logic [2:0]  ccnt;
  } parse_state_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        has_byte;
    logic        last_of_packet;
    logic        track;
    logic [31:0] time_ms;
    logic        short_tag;
  } result_t;

endpackage

// ===== rtl/core/flvtd_step.sv =====
// Per-byte tag parser: next parse state and optional result word.
// Depends on flvtd_pkg.
module flvtd_step import flvtd_pkg::*; (
  input  parse_state_t st,
  input  logic [7:0]   b,
  output parse_state_t st_next,
  output logic         emit,
  output result_t      res
);

  logic [23:0] left_dec;
  logic        zero;
  logic        codec;
  logic [2:0]  ccnt_inc;
  logic        r_has;
  logic        r_last;
  logic        r_short;

  assign left_dec = st.left - 24'd1;
  assign zero     = (left_dec == 24'd0);
  assign ccnt_inc = st.ccnt + 3'd1;
  assign codec    = (st.kind == KIND_AUDIO) ? ((b & AUDIO_MASK) == AUDIO_AAC)
                                            : ((b & VIDEO_MASK) == VIDEO_AVC);

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    r_has   = 1'b0;
    r_last  = 1'b0;
    r_short = 1'b0;
    case (st.phase)
      PH_FLAG: begin
        st_next.left = left_dec;
        if (codec) begin
          if (zero) begin
            st_next.phase = PH_HEADER;
            emit = 1'b1;
            r_short = 1'b1;
          end else begin
            st_next.phase = PH_PKTTYPE;
          end
        end else if (zero) begin
          st_next.phase = PH_HEADER;
          emit = 1'b1;
          r_last = 1'b1;
        end else begin
          st_next.phase = PH_PAYLOAD;
        end
      end
      PH_PKTTYPE: begin
        st_next.left = left_dec;
        if (b != PKT_RAW) begin
          st_next.phase = zero ? PH_HEADER : PH_SKIP;
        end else if (st.kind == KIND_AUDIO) begin
          if (zero) begin
            st_next.phase = PH_HEADER;
            emit = 1'b1;
            r_last = 1'b1;
          end else begin
            st_next.phase = PH_PAYLOAD;
          end
        end else if (left_dec < 24'd3) begin
          st_next.phase = zero ? PH_HEADER : PH_SKIP;
          emit = 1'b1;
          r_short = 1'b1;
        end else begin
          st_next.ccnt  = 3'd0;
          st_next.phase = PH_CTS;
        end
      end
      PH_CTS: begin
        st_next.left = left_dec;
        st_next.ccnt = ccnt_inc;
        if (ccnt_inc >= CTS_BYTES) begin
          st_next.ccnt = 3'd0;
          if (zero) begin
            st_next.phase = PH_HEADER;
            emit = 1'b1;
            r_last = 1'b1;
          end else begin
            st_next.phase = PH_PAYLOAD;
          end
        end else if (zero) begin
          st_next.phase = PH_HEADER;
        end
      end
      PH_PAYLOAD: begin
        st_next.left = left_dec;
        emit   = 1'b1;
        r_has  = 1'b1;
        r_last = zero;
        if (zero) begin
          st_next.phase = PH_HEADER;
        end
      end
      PH_SKIP: begin
        st_next.left = left_dec;
        if (zero) begin
          st_next.phase = PH_HEADER;
        end
      end
      default: begin
        // header bytes, also the unused phase codes
        st_next.phase = PH_HEADER;
        if (st.hpos == 4'd4) begin
          st_next.kind = b;
        end
        if (st.hpos inside {[4'd5:4'd7]}) begin
          st_next.left = {st.left[15:0], b};
        end
        if (st.hpos == 4'd8) begin
          st_next.tag_time = {8'h00, b, 16'h0000};
        end
        if (st.hpos inside {4'd9, 4'd10}) begin
          st_next.tag_time = {8'h00, st.tag_time[23:16], st.tag_time[7:0], b};
        end
        if (st.hpos == 4'd11) begin
          st_next.tag_time = {b, st.tag_time[23:0]};
        end
        if (st.hpos >= HDR_LAST_POS) begin
          st_next.hpos = 4'd0;
          st_next.ccnt = 3'd0;
          if (st.left == 24'd0) begin
            st_next.phase = PH_HEADER;
          end else if (st.kind == KIND_AUDIO || st.kind == KIND_VIDEO) begin
            st_next.phase = PH_FLAG;
          end else begin
            st_next.phase = PH_SKIP;
          end
        end else begin
          st_next.hpos = st.hpos + 4'd1;
        end
      end
    endcase
  end

  always_comb begin
    res.payload_byte   = r_has ? b : 8'h00;
    res.has_byte       = r_has;
    res.last_of_packet = r_last;
    res.track          = (st.kind == KIND_VIDEO);
    res.time_ms        = st.tag_time;
    res.short_tag      = r_short;
  end

endmodule

// ===== rtl/core/flvtd_out_fifo.sv =====
// Two-word result buffer parting the parser from the output stall.
// Depends on flvtd_pkg.
module flvtd_out_fifo import flvtd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_word,
  output logic    full,
  output logic    valid,
  input  logic    stall,
  output result_t word
);

  result_t    mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign pop   = valid && !stall;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign word = mem[rd_ptr];

endmodule

// ===== rtl/core/flv_tag_demuxer.sv =====
// FLV tag demuxer top level: input register, parser state, result buffer.
// Each word passes the input register and then the result buffer before the outputs.
// One byte per cycle while the buffer is not full; the parser step is combinational.
// Input stall comes from registers; it rises only when the two-word buffer is full.
// Reset (rst, synchronous, active high) returns the parser to the header phase.
`include "flv_tag_demuxer_defines.svh"
module flv_tag_demuxer import flvtd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        stream_valid,
  output logic        stream_stall,
  input  logic [7:0]  stream_byte,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  payload_byte,
  output logic        has_byte,
  output logic        last_of_packet,
  output logic        track,
  output logic [31:0] time_ms,
  output logic        short_tag
);

  logic         in_vld;
  logic [7:0]   in_byte;
  logic         fifo_full;
  logic         advance;
  parse_state_t st;
  parse_state_t st_next;
  logic         emit;
  result_t      res;
  result_t      out_word;

  assign stream_stall = in_vld && fifo_full;
  assign advance      = in_vld && !fifo_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (!stream_stall) begin
      in_vld <= stream_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stream_valid && !stream_stall) begin
      in_byte <= stream_byte;
    end
  end

  flvtd_step u_step (
    .st      (st),
    .b       (in_byte),
    .st_next (st_next),
    .emit    (emit),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      st.phase    <= PH_HEADER;
      st.hpos     <= 4'd0;
      st.kind     <= 8'h00;
      st.left     <= 24'd0;
      st.tag_time <= 32'd0;
      st.ccnt     <= 3'd0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  flvtd_out_fifo u_out (
    .clk       (clk),
    .rst       (rst),
    .push      (advance && emit),
    .push_word (res),
    .full      (fifo_full),
    .valid     (result_valid),
    .stall     (result_stall),
    .word      (out_word)
  );

  assign payload_byte   = out_word.payload_byte;
  assign has_byte       = out_word.has_byte;
  assign last_of_packet = out_word.last_of_packet;
  assign track          = out_word.track;
  assign time_ms        = out_word.time_ms;
  assign short_tag      = out_word.short_tag;

  `FLVTD_ASSERT_IMPL(a_stall_needs_word, stream_stall, in_vld)
  `FLVTD_ASSERT_IMPL(a_short_no_byte, result_valid && short_tag, !has_byte && !last_of_packet)
  `FLVTD_ASSERT_NEVER(a_hpos_header_only, st.phase != PH_HEADER && st.hpos != 4'd0)
  `FLVTD_ASSERT_IMPL(a_cts_video_only, st.phase == PH_CTS, st.kind == KIND_VIDEO)

endmodule
